// ----- src/sorted_key_table_core_defines.svh -----
// Assertion macros shared by the sorted key table RTL
`ifndef SORTED_KEY_TABLE_CORE_DEFINES_SVH
`define SORTED_KEY_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define SKT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define SKT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/skt_pkg.sv -----
// Shared constants, types and helpers for the sorted key table
`default_nettype none

package skt_pkg;

	localparam int CAPACITY = 256;
	localparam int KEY_BITS = 32;
	localparam int VAL_BITS = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// OR-tree fan-in of the first reduction stage
	localparam int GROUP    = 16;
	localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [VAL_BITS-1:0] val_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_REMOVE = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_RED1,
		ST_RED2,
		ST_APPLY
	} state_t;

	// Broadcast control to every cell of the chain
	typedef struct packed {
		logic cmp;  // latch compare flags against the request key
		logic ins;  // insert shift: take new pair or left neighbour
		logic rm;   // remove shift: take right neighbour
	} cell_ctl_t;

	// Key as stored: low KEY_BITS bits of the bus key, zero-extended if wider
	function automatic key_t key_trim(input logic [31:0] k);
		return key_t'(k);
	endfunction

endpackage

`default_nettype wire

// ----- src/skt_cell.sv -----
// One table slot: key/value pair, compare flags and neighbour shift
`default_nettype none

module skt_cell (
	input  wire                logic  clk,
	input  wire                logic  arst_n,
	input  skt_pkg::cell_ctl_t        ctl,
	input  wire                logic  valid,
	input  skt_pkg::key_t             req_key,
	input  skt_pkg::val_t             req_val,
	input  skt_pkg::key_t             left_key,
	input  skt_pkg::val_t             left_val,
	input  wire                logic  left_lt,
	input  wire                logic  left_eq,
	input  skt_pkg::key_t             right_key,
	input  skt_pkg::val_t             right_val,
	output skt_pkg::key_t             key,
	output skt_pkg::val_t             value,
	output logic                      lt,
	output logic                      eq,
	output logic                      hit
);

	skt_pkg::key_t key_q;
	skt_pkg::val_t value_q;
	skt_pkg::key_t key_d;
	skt_pkg::val_t value_d;
	logic          lt_q;
	logic          eq_q;

	// Next pair: hold, take new pair, shift up from left or down from right
	always_comb begin
		key_d   = key_q;
		value_d = value_q;
		if (ctl.ins && !lt_q) begin
			if (left_lt) begin
				key_d   = req_key;
				value_d = req_val;
			end else begin
				key_d   = left_key;
				value_d = left_val;
			end
		end else if (ctl.rm && !lt_q) begin
			key_d   = right_key;
			value_d = right_val;
		end
	end

	// Pair storage, undefined until written
	always_ff @(posedge clk) begin
		key_q   <= key_d;
		value_q <= value_d;
	end

	// Compare flags against the request key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp) begin
			lt_q <= valid && (key_q < req_key);
			eq_q <= valid && (key_q == req_key);
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign lt    = lt_q;
	assign eq    = eq_q;
	// first equal key: equal keys sit together, so the left one differs
	assign hit   = eq_q && !left_eq;

endmodule

`default_nettype wire

// ----- src/skt_reduce.sv -----
// Two-stage registered OR tree: hit flag and matched value
`default_nettype none

module skt_reduce (
	input  wire           logic                           clk,
	input  wire           logic                           arst_n,
	input  wire           logic [skt_pkg::CAPACITY-1:0]   hit,
	input  skt_pkg::val_t                                 value [skt_pkg::CAPACITY],
	output logic                                          found,
	output skt_pkg::val_t                                 value_out
);

	logic          grp_hit_d [skt_pkg::NGROUP];
	skt_pkg::val_t grp_val_d [skt_pkg::NGROUP];
	logic          grp_hit_s1 [skt_pkg::NGROUP];
	skt_pkg::val_t grp_val_s1 [skt_pkg::NGROUP];
	logic          found_d;
	skt_pkg::val_t val_d;
	logic          found_s2;
	skt_pkg::val_t val_s2;

	// Stage 1: OR within each group of cells
	always_comb begin
		for (int g = 0; g < skt_pkg::NGROUP; g++) begin
			grp_hit_d[g] = 1'b0;
			grp_val_d[g] = '0;
			for (int j = 0; j < skt_pkg::GROUP; j++) begin
				if (g * skt_pkg::GROUP + j < skt_pkg::CAPACITY) begin
					grp_hit_d[g] = grp_hit_d[g] | hit[g * skt_pkg::GROUP + j];
					grp_val_d[g] = grp_val_d[g] |
						(hit[g * skt_pkg::GROUP + j] ?
						 value[g * skt_pkg::GROUP + j] : '0);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < skt_pkg::NGROUP; g++) begin
				grp_hit_s1[g] <= 1'b0;
			end
		end else begin
			for (int g = 0; g < skt_pkg::NGROUP; g++) begin
				grp_hit_s1[g] <= grp_hit_d[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < skt_pkg::NGROUP; g++) begin
			grp_val_s1[g] <= grp_val_d[g];
		end
	end

	// Stage 2: OR across groups
	always_comb begin
		found_d = 1'b0;
		val_d   = '0;
		for (int g = 0; g < skt_pkg::NGROUP; g++) begin
			found_d = found_d | grp_hit_s1[g];
			val_d   = val_d | grp_val_s1[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_s2 <= 1'b0;
		end else begin
			found_s2 <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		val_s2 <= val_d;
	end

	assign found     = found_s2;
	assign value_out = val_s2;

endmodule

`default_nettype wire

// ----- src/sorted_key_table_core.sv -----
// Sorted key table: top level with request sequencer and cell chain
//
//  channel  | dir | handshake               | contents
//  ---------+-----+-------------------------+--------------------------------------
//  s_axis   | in  | s_axis_tvalid/_tready   | request beat: type, key, value
//  m_axis   | out | m_axis_tvalid/_tready   | result beat: found, value, count, full
//  cfg      | in  | cfg_we                  | max_entries, written with no wait
//
// One request is in flight at a time. With the result side free it passes through the
// accepting cycle in idle, compare in every cell, two OR-tree stages for the match,
// then the shift through the chain in the step that also loads the result register.
// A result beat still waiting for m_axis_tready holds the next request in its last
// step, and the input stays not ready until that step completes.
// Reset empties the table at once and sets max_entries to 256.
`default_nettype none
`include "sorted_key_table_core_defines.svh"

module sorted_key_table_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// request beat
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [95:0]  s_axis_tdata,  // [31:0] key, [95:32] value_in
	input  wire logic [1:0]   s_axis_tuser,  // [1:0] req_type
	// result beat
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [79:0]       m_axis_tdata,  // [63:0] value_out, [72:64] entry_count, pad
	output logic [1:0]        m_axis_tuser,  // [0] found, [1] full_res
	// limit register
	input  wire logic         cfg_we,
	input  wire logic [8:0]   cfg_wdata
);

	localparam int N = skt_pkg::CAPACITY;

	skt_pkg::state_t    state_q;
	skt_pkg::state_t    state_d;
	skt_pkg::req_t      req_q;
	skt_pkg::key_t      key_q;
	skt_pkg::val_t      val_q;
	skt_pkg::cnt_t      count_q;
	skt_pkg::cnt_t      count_d;
	logic [8:0]         max_entries_q;
	skt_pkg::cell_ctl_t ctl;
	logic               load_out;
	logic               table_full;

	logic               out_valid_q;
	logic               out_found_q;
	logic               out_full_q;
	skt_pkg::val_t      out_val_q;
	logic [8:0]         out_count_q;
	logic               res_found;
	logic               res_full;
	skt_pkg::val_t      res_val;

	skt_pkg::key_t      cell_key [N];
	skt_pkg::val_t      cell_val [N];
	logic [N-1:0]       cell_lt;
	logic [N-1:0]       cell_eq;
	logic [N-1:0]       cell_hit;
	logic               red_found;
	skt_pkg::val_t      red_val;

	// Limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= 9'd256;
		end else if (cfg_we) begin
			max_entries_q <= cfg_wdata;
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_q <= skt_pkg::req_t'(s_axis_tuser);
			key_q <= skt_pkg::key_trim(s_axis_tdata[31:0]);
			val_q <= s_axis_tdata[95:32];
		end
	end

	assign table_full = (32'(count_q) >= 32'(max_entries_q)) || (32'(count_q) >= N);

	// Sequencer: next state and cell control
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		ctl           = '0;
		load_out      = 1'b0;
		case (state_q)
			skt_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = skt_pkg::ST_CMP;
				end
			end
			skt_pkg::ST_CMP: begin
				ctl.cmp = 1'b1;
				state_d = skt_pkg::ST_RED1;
			end
			skt_pkg::ST_RED1: begin
				state_d = skt_pkg::ST_RED2;
			end
			skt_pkg::ST_RED2: begin
				state_d = skt_pkg::ST_APPLY;
			end
			skt_pkg::ST_APPLY: begin
				if (!out_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					ctl.ins  = (req_q == skt_pkg::REQ_INSERT) && !table_full;
					ctl.rm   = (req_q == skt_pkg::REQ_REMOVE) && red_found;
					state_d  = skt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = skt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result fields and new count
	always_comb begin
		res_found = 1'b0;
		res_full  = 1'b0;
		res_val   = '0;
		count_d   = count_q;
		case (req_q)
			skt_pkg::REQ_INSERT: begin
				res_full = table_full;
				if (!table_full) begin
					count_d = count_q + 1'b1;
				end
			end
			skt_pkg::REQ_LOOKUP: begin
				res_found = red_found;
				res_val   = red_found ? red_val : '0;
			end
			skt_pkg::REQ_REMOVE: begin
				res_found = red_found;
				if (red_found) begin
					count_d = count_q - 1'b1;
				end
			end
			default: begin
				res_found = 1'b0;
			end
		endcase
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load_out) begin
			count_q <= count_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_found_q <= res_found;
			out_full_q  <= res_full;
			out_val_q   <= res_val;
			out_count_q <= 9'(count_d);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_count_q, out_val_q};
	assign m_axis_tuser  = {out_full_q, out_found_q};

	// Cell chain: cell 0 holds the smallest key
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic          valid;
		logic          left_lt;
		logic          left_eq;
		skt_pkg::key_t left_key;
		skt_pkg::val_t left_val;
		skt_pkg::key_t right_key;
		skt_pkg::val_t right_val;

		assign valid = 32'(count_q) > i;

		if (i == 0) begin : g_first
			assign left_lt  = 1'b1;
			assign left_eq  = 1'b0;
			assign left_key = key_q;
			assign left_val = val_q;
		end else begin : g_inner
			assign left_lt  = cell_lt[i-1];
			assign left_eq  = cell_eq[i-1];
			assign left_key = cell_key[i-1];
			assign left_val = cell_val[i-1];
		end

		if (i == N - 1) begin : g_last
			assign right_key = cell_key[i];
			assign right_val = cell_val[i];
		end else begin : g_body
			assign right_key = cell_key[i+1];
			assign right_val = cell_val[i+1];
		end

		skt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.valid     (valid),
			.req_key   (key_q),
			.req_val   (val_q),
			.left_key  (left_key),
			.left_val  (left_val),
			.left_lt   (left_lt),
			.left_eq   (left_eq),
			.right_key (right_key),
			.right_val (right_val),
			.key       (cell_key[i]),
			.value     (cell_val[i]),
			.lt        (cell_lt[i]),
			.eq        (cell_eq[i]),
			.hit       (cell_hit[i])
		);
	end

	// Match reduction over the chain
	skt_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.hit       (cell_hit),
		.value     (cell_val),
		.found     (red_found),
		.value_out (red_val)
	);

	// Checks
	`SKT_ASSERT_IMP(a_count_cap, 1'b1, 32'(count_q) <= N, "fill count above capacity")
	`SKT_ASSERT_NXT(a_accept_cmp, s_axis_tvalid && s_axis_tready, state_q == skt_pkg::ST_CMP, "accepted beat did not start compare")
	`SKT_ASSERT_IMP(a_one_hit, 1'b1, $onehot0(cell_hit), "more than one first-equal cell")
	`SKT_ASSERT_NXT(a_rm_count, load_out && ctl.rm, count_q == $past(count_q) - 1'b1, "remove hit did not drop the count")
	`SKT_ASSERT_IMP(a_full_count, out_valid_q && out_full_q, 32'(out_count_q) == 32'(count_q), "refused insert changed the count")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the sorted key table: directed and random requests
`default_nettype none

module tb_top;

	localparam logic [1:0] REQ_BAD = 2'd3;   // unknown request code
	localparam int POOL_SIZE = 16;
	localparam int DRAIN_CYCLES = 12;        // settling time, longer than one request's pass through the block
	localparam int IDLE_LIMIT = 5000;
	localparam int MAX_REPORTS = 10;

	// One expected result, with the request that caused it for the report
	typedef struct {
		logic [1:0]    req;
		skt_pkg::key_t key;
		logic          found;
		skt_pkg::val_t value;
		skt_pkg::cnt_t count;
		logic          full;
	} table_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;   // [31:0] key, [95:32] value_in
	logic [1:0]  s_axis_tuser;   // [1:0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;   // [63:0] value_out, [72:64] entry_count, pad
	logic [1:0]  m_axis_tuser;   // [0] found, [1] full_res
	logic        cfg_we;
	logic [8:0]  cfg_wdata;

	// Shadow copy of the table
	skt_pkg::key_t shadow_key[skt_pkg::CAPACITY];
	skt_pkg::val_t shadow_val[skt_pkg::CAPACITY];
	int unsigned   shadow_cnt;
	logic [8:0]    shadow_max;

	table_result_t pending_results[$];
	skt_pkg::key_t key_pool[POOL_SIZE];
	int            mismatches;
	int            stall_left;
	bit            calm;

	sorted_key_table_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Mostly short or no gaps, now and then a long one; none while calm is set
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(40, 20);
	endfunction

	// Apply one request to the shadow table and return what the block should answer
	function automatic table_result_t table_apply(input logic [1:0] req,
			input skt_pkg::key_t k, input skt_pkg::val_t v);
		table_result_t res;
		int unsigned limit;
		int unsigned pos;
		res.req = req;
		res.key = k;
		res.found = 1'b0;
		res.value = '0;
		res.full = 1'b0;
		limit = (shadow_max > skt_pkg::CAPACITY) ? skt_pkg::CAPACITY : shadow_max;
		pos = 0;
		if (req == skt_pkg::REQ_INSERT) begin
			if (shadow_cnt >= limit) begin
				res.full = 1'b1;
			end else begin
				while (pos < shadow_cnt && shadow_key[pos] < k)
					pos++;
				for (int unsigned i = shadow_cnt; i > pos; i--) begin
					shadow_key[i] = shadow_key[i-1];
					shadow_val[i] = shadow_val[i-1];
				end
				shadow_key[pos] = k;
				shadow_val[pos] = v;
				shadow_cnt++;
			end
		end else if (req == skt_pkg::REQ_LOOKUP || req == skt_pkg::REQ_REMOVE) begin
			while (pos < shadow_cnt && shadow_key[pos] != k)
				pos++;
			if (pos < shadow_cnt) begin
				res.found = 1'b1;
				if (req == skt_pkg::REQ_LOOKUP) begin
					res.value = shadow_val[pos];
				end else begin
					for (int unsigned i = pos; i + 1 < shadow_cnt; i++) begin
						shadow_key[i] = shadow_key[i+1];
						shadow_val[i] = shadow_val[i+1];
					end
					shadow_cnt--;
				end
			end
		end
		res.count = skt_pkg::cnt_t'(shadow_cnt);
		return res;
	endfunction

	// Send one request beat; tvalid is left high so back-to-back beats need no toggle
	task automatic send_req(input logic [1:0] req, input skt_pkg::key_t k,
			input skt_pkg::val_t v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {v, k};
		s_axis_tuser <= req;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(table_apply(req, k, v));
	endtask

	// Drop tvalid and wait until every result is in and the block has settled
	task automatic wait_idle();
		int waited;
		waited = 0;
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0 && waited < IDLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0) begin
			$display("%0d results never arrived", pending_results.size());
			mismatches++;
			pending_results.delete();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [8:0] m);
		wait_idle();
		cfg_wdata <= m;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_max = m;
	endtask

	function automatic skt_pkg::val_t rand_val();
		return {$urandom, $urandom};
	endfunction

	function automatic skt_pkg::key_t pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 40 && shadow_cnt > 0)
			return shadow_key[$urandom_range(shadow_cnt - 1)];
		if (r < 80)
			return key_pool[$urandom_range(POOL_SIZE - 1)];
		return skt_pkg::key_t'($urandom);
	endfunction

	// Empty table, extreme keys and values, duplicates, misses, unknown code
	task automatic test_basic_ops();
		send_req(skt_pkg::REQ_LOOKUP, '0, '0);
		send_req(skt_pkg::REQ_REMOVE, '1, '0);
		send_req(REQ_BAD, '1, '1);
		send_req(skt_pkg::REQ_INSERT, '0, '1);
		send_req(skt_pkg::REQ_INSERT, '1, '0);
		send_req(skt_pkg::REQ_INSERT, skt_pkg::key_t'(5),
			skt_pkg::val_t'(64'h0123_4567_89ab_cdef));
		// newer duplicate must sit ahead of the older one
		send_req(skt_pkg::REQ_INSERT, skt_pkg::key_t'(5),
			skt_pkg::val_t'(64'hfedc_ba98_7654_3210));
		send_req(skt_pkg::REQ_LOOKUP, skt_pkg::key_t'(5), '0);
		send_req(skt_pkg::REQ_LOOKUP, '0, '0);
		send_req(skt_pkg::REQ_LOOKUP, '1, '1);
		send_req(skt_pkg::REQ_REMOVE, skt_pkg::key_t'(5), '0);
		send_req(skt_pkg::REQ_LOOKUP, skt_pkg::key_t'(5), '0);
		send_req(skt_pkg::REQ_REMOVE, skt_pkg::key_t'(7), '0);
		send_req(skt_pkg::REQ_REMOVE, '0, '0);
		send_req(skt_pkg::REQ_LOOKUP, '0, '0);
		send_req(REQ_BAD, skt_pkg::key_t'(5), rand_val());
	endtask

	// Limit of zero, limit of one, capped limit, limit dropped under the count
	task automatic test_limit_edges();
		set_limit(9'd0);
		send_req(skt_pkg::REQ_INSERT, skt_pkg::key_t'(3), rand_val());
		send_req(skt_pkg::REQ_LOOKUP, skt_pkg::key_t'(5), '0);
		send_req(skt_pkg::REQ_REMOVE, skt_pkg::key_t'(5), '0);
		set_limit(9'd1);
		send_req(skt_pkg::REQ_INSERT, skt_pkg::key_t'(3), rand_val());
		send_req(skt_pkg::REQ_REMOVE, '1, '0);
		send_req(skt_pkg::REQ_INSERT, skt_pkg::key_t'(9), rand_val());
		send_req(skt_pkg::REQ_INSERT, skt_pkg::key_t'(10), rand_val());
		set_limit(9'd511);
		send_req(skt_pkg::REQ_INSERT, skt_pkg::key_t'(10), rand_val());
		send_req(skt_pkg::REQ_INSERT, skt_pkg::key_t'(2), rand_val());
		set_limit(9'd2);
		send_req(skt_pkg::REQ_INSERT, skt_pkg::key_t'(4), rand_val());
		send_req(skt_pkg::REQ_LOOKUP, skt_pkg::key_t'(10), '0);
		send_req(skt_pkg::REQ_REMOVE, skt_pkg::key_t'(9), '0);
		send_req(skt_pkg::REQ_INSERT, skt_pkg::key_t'(4), rand_val());
	endtask

	// Fill to capacity, push past it, then a limit one below full
	task automatic test_fill_to_capacity();
		set_limit(9'd256);
		calm = 1'b1;
		while (shadow_cnt < skt_pkg::CAPACITY) begin
			if (shadow_cnt == skt_pkg::CAPACITY / 2)
				calm = 1'b0;
			send_req(skt_pkg::REQ_INSERT,
				($urandom_range(3) == 0) ? pick_key() : skt_pkg::key_t'($urandom),
				rand_val());
		end
		send_req(skt_pkg::REQ_INSERT, '0, rand_val());
		send_req(skt_pkg::REQ_INSERT, '1, rand_val());
		send_req(skt_pkg::REQ_LOOKUP, pick_key(), '0);
		set_limit(9'd255);
		send_req(skt_pkg::REQ_INSERT, pick_key(), rand_val());
		send_req(skt_pkg::REQ_REMOVE, pick_key(), '0);
		send_req(skt_pkg::REQ_INSERT, pick_key(), rand_val());
		send_req(skt_pkg::REQ_REMOVE, pick_key(), '0);
		send_req(skt_pkg::REQ_INSERT, pick_key(), rand_val());
	endtask

	// Random mix with the given percentages; the rest is unknown codes
	task automatic run_mix(input int n, input int ins_pct, input int look_pct,
			input int rm_pct);
		int r;
		logic [1:0] req;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < ins_pct)
				req = skt_pkg::REQ_INSERT;
			else if (r < ins_pct + look_pct)
				req = skt_pkg::REQ_LOOKUP;
			else if (r < ins_pct + look_pct + rm_pct)
				req = skt_pkg::REQ_REMOVE;
			else
				req = REQ_BAD;
			send_req(req, pick_key(), rand_val());
		end
	endtask

	task automatic test_random_traffic();
		set_limit(9'd256);
		run_mix(90, 15, 20, 60);
		set_limit(9'($urandom_range(32, 1)));
		run_mix(70, 40, 25, 30);
		set_limit(9'd511);
		run_mix(70, 60, 20, 15);
		set_limit(9'($urandom_range(511)));
		run_mix(50, 40, 25, 30);
	endtask

	// Result sink stalls
	always @(posedge clk) begin : ready_drive
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	// Compare every accepted result beat with the oldest expectation
	always @(posedge clk) begin : result_check
		table_result_t want;
		logic          got_found;
		logic          got_full;
		skt_pkg::val_t got_value;
		skt_pkg::cnt_t got_count;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_found = m_axis_tuser[0];
			got_full = m_axis_tuser[1];
			got_value = m_axis_tdata[63:0];
			got_count = m_axis_tdata[72:64];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: found=%0b value=%h count=%0d full=%0b",
						got_found, got_value, got_count, got_full);
			end else begin
				want = pending_results.pop_front();
				if (got_found !== want.found || got_value !== want.value
						|| got_count !== want.count || got_full !== want.full) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"mismatch req=%0d key=%h: expected found=%0b value=%h ",
							"count=%0d full=%0b, got found=%0b value=%h count=%0d full=%0b"},
							want.req, want.key, want.found, want.value, want.count,
							want.full, got_found, got_value, got_count, got_full);
				end
			end
		end
	end

	// Sequence of tests
	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		mismatches = 0;
		stall_left = 0;
		calm = 1'b0;
		shadow_cnt = 0;
		shadow_max = 9'd256;
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = skt_pkg::key_t'(1);
		key_pool[3] = skt_pkg::key_t'(32'h8000_0000);
		key_pool[4] = skt_pkg::key_t'(32'h7fff_ffff);
		for (int i = 5; i < POOL_SIZE; i++)
			key_pool[i] = skt_pkg::key_t'($urandom);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_limit_edges();
		test_fill_to_capacity();
		test_random_traffic();
		wait_idle();

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
